### hw/rtl/fpalu_pkg.sv
// Shared payload types and operation codes for the fixed-point ALU.
package fpalu_pkg;

   // operation codes carried in the mode field
   localparam logic [3:0] MODE_ADD = 4'd0;
   localparam logic [3:0] MODE_SUB = 4'd1;
   localparam logic [3:0] MODE_MUL = 4'd2;
   localparam logic [3:0] MODE_DIV = 4'd3;
   localparam logic [3:0] MODE_MIN = 4'd4;
   localparam logic [3:0] MODE_MAX = 4'd5;
   localparam logic [3:0] MODE_INC = 4'd6;
   localparam logic [3:0] MODE_DEC = 4'd7;
   localparam logic [3:0] MODE_I2F = 4'd8;
   localparam logic [3:0] MODE_F2I = 4'd9;

   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less;
      logic               a_greater;
      logic               a_equal;
      logic               saturated;
      logic               divide_by_zero;
   } rsp_type;

endpackage

### hw/rtl/fixed_point_alu.sv
// Pipelined signed fixed-point ALU with saturation and a restoring divider.
//
// Signed fixed-point ALU with FRAC_BITS fractional bits. One operation is
// accepted every cycle and results leave in order, one per cycle. Every
// operation travels the same pipeline, whose depth is set by the divider,
// which resolves one quotient bit per stage over 32 + FRAC_BITS stages.
// Multiply and divide round to nearest, ties away from zero; overflow
// saturates and sets saturated; division by zero returns zero.
// When rsp is stalled the whole pipeline holds.
module fixed_point_alu
   import fpalu_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NW = 32 + FRAC_BITS;
   localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

   logic en;
   assign en        = rsp_ready || !rsp_valid;
   assign req_ready = en;

   // ---------------- stage 1: input register
   logic               s1_v_ff;
   logic [3:0]         s1_mode_ff;
   logic signed [31:0] s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
      if (en) begin
         s1_mode_ff <= req_data.mode;
         s1_a_ff    <= req_data.operand_a;
         s1_b_ff    <= req_data.operand_b;
      end
   end

   // ---------------- stage 2: compare, simple ops, product, divider setup
   logic signed [63:0] prod_in;
   logic signed [32:0] sum_in, dif_in, inc_in, dec_in;
   logic signed [NW-1:0] i2f_in;
   logic signed [31:0] res2_in;
   logic               sat2_in;
   logic [31:0]        absa_in, absb_in;

   assign prod_in = 64'(s1_a_ff) * 64'(s1_b_ff);
   assign sum_in  = 33'(s1_a_ff) + 33'(s1_b_ff);
   assign dif_in  = 33'(s1_a_ff) - 33'(s1_b_ff);
   assign inc_in  = 33'(s1_a_ff) + 33'sd1;
   assign dec_in  = 33'(s1_a_ff) - 33'sd1;
   assign i2f_in  = {s1_a_ff, FRAC_BITS'(0)};
   assign absa_in = s1_a_ff[31] ? 32'(-s1_a_ff) : 32'(s1_a_ff);
   assign absb_in = s1_b_ff[31] ? 32'(-s1_b_ff) : 32'(s1_b_ff);

   // clamp a 33-bit sum to 32 bits
   function automatic logic [32:0] clamp33(input logic signed [32:0] v);
      if (v[32] != v[31]) return {1'b1, (v[32] ? MIN32 : MAX32)};
      return {1'b0, v[31:0]};
   endfunction

   always_comb begin
      res2_in = '0;
      sat2_in = 1'b0;
      unique case (s1_mode_ff)
         MODE_ADD: {sat2_in, res2_in} = clamp33(sum_in);
         MODE_SUB: {sat2_in, res2_in} = clamp33(dif_in);
         MODE_INC: {sat2_in, res2_in} = clamp33(inc_in);
         MODE_DEC: {sat2_in, res2_in} = clamp33(dec_in);
         MODE_MIN: res2_in = (s1_a_ff < s1_b_ff) ? s1_a_ff : s1_b_ff;
         MODE_MAX: res2_in = (s1_a_ff > s1_b_ff) ? s1_a_ff : s1_b_ff;
         MODE_I2F: begin
            if ((&i2f_in[NW-1:31]) || !(|i2f_in[NW-1:31])) begin
               res2_in = i2f_in[31:0];
            end else begin
               sat2_in = 1'b1;
               res2_in = s1_a_ff[31] ? MIN32 : MAX32;
            end
         end
         MODE_F2I: res2_in = s1_a_ff >>> FRAC_BITS;
         default: res2_in = '0;
      endcase
   end

   logic               s2_v_ff;
   logic [3:0]         s2_mode_ff;
   logic               s2_lt_ff, s2_gt_ff, s2_eq_ff, s2_sat_ff, s2_dz_ff, s2_neg_ff;
   logic signed [31:0] s2_res_ff;
   logic signed [63:0] s2_prod_ff;
   logic [NW-1:0]      s2_n_ff;
   logic [31:0]        s2_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         s2_mode_ff <= s1_mode_ff;
         s2_lt_ff   <= s1_a_ff < s1_b_ff;
         s2_gt_ff   <= s1_a_ff > s1_b_ff;
         s2_eq_ff   <= s1_a_ff == s1_b_ff;
         s2_res_ff  <= res2_in;
         s2_sat_ff  <= sat2_in;
         s2_dz_ff   <= (s1_mode_ff == MODE_DIV) && (s1_b_ff == '0);
         s2_neg_ff  <= s1_a_ff[31] ^ s1_b_ff[31];
         s2_prod_ff <= prod_in;
         s2_n_ff    <= {absa_in, FRAC_BITS'(0)};
         s2_d_ff    <= absb_in;
      end
   end

   // ---------------- stage 3: product magnitude
   logic               s3_v_ff;
   logic [3:0]         s3_mode_ff;
   logic               s3_lt_ff, s3_gt_ff, s3_eq_ff, s3_sat_ff, s3_dz_ff, s3_neg_ff;
   logic signed [31:0] s3_res_ff;
   logic [63:0]        s3_mag_ff;
   logic               s3_pneg_ff;
   logic [NW-1:0]      s3_n_ff;
   logic [31:0]        s3_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s3_mode_ff <= s2_mode_ff;
         s3_lt_ff   <= s2_lt_ff;
         s3_gt_ff   <= s2_gt_ff;
         s3_eq_ff   <= s2_eq_ff;
         s3_res_ff  <= s2_res_ff;
         s3_sat_ff  <= s2_sat_ff;
         s3_dz_ff   <= s2_dz_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_mag_ff  <= s2_prod_ff[63] ? 64'(-s2_prod_ff) : 64'(s2_prod_ff);
         s3_pneg_ff <= s2_prod_ff[63];
         s3_n_ff    <= s2_n_ff;
         s3_d_ff    <= s2_d_ff;
      end
   end

   // ---------------- stage 4: product rounding and clamp
   logic [63:0]        mround_in;
   logic signed [31:0] res4_in;
   logic               sat4_in;

   assign mround_in = (s3_mag_ff + HALF) >> FRAC_BITS;

   always_comb begin
      res4_in = s3_res_ff;
      sat4_in = s3_sat_ff;
      if (s3_mode_ff == MODE_MUL) begin
         if (s3_pneg_ff) begin
            if ((|mround_in[63:32]) || (mround_in[31] && (|mround_in[30:0]))) begin
               res4_in = MIN32;
               sat4_in = 1'b1;
            end else begin
               res4_in = 32'(-mround_in[31:0]);
               sat4_in = 1'b0;
            end
         end else if (|mround_in[63:31]) begin
            res4_in = MAX32;
            sat4_in = 1'b1;
         end else begin
            res4_in = mround_in[31:0];
            sat4_in = 1'b0;
         end
      end
   end

   // ---------------- divider chain, one quotient bit per stage
   logic               cv_ff   [NW+1];
   logic [3:0]         cmode_ff[NW+1];
   logic               clt_ff  [NW+1];
   logic               cgt_ff  [NW+1];
   logic               ceq_ff  [NW+1];
   logic signed [31:0] cres_ff [NW+1];
   logic               csat_ff [NW+1];
   logic               cdz_ff  [NW+1];
   logic               cneg_ff [NW+1];
   logic [31:0]        cd_ff   [NW+1];
   logic [31:0]        crem_ff [NW+1];
   logic [NW-1:0]      cnq_ff  [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= s3_v_ff;
      end
      if (en) begin
         cmode_ff[0] <= s3_mode_ff;
         clt_ff[0]   <= s3_lt_ff;
         cgt_ff[0]   <= s3_gt_ff;
         ceq_ff[0]   <= s3_eq_ff;
         cres_ff[0]  <= res4_in;
         csat_ff[0]  <= sat4_in;
         cdz_ff[0]   <= s3_dz_ff;
         cneg_ff[0]  <= s3_neg_ff;
         cd_ff[0]    <= s3_d_ff;
         crem_ff[0]  <= '0;
         cnq_ff[0]   <= s3_n_ff;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_div
      logic [32:0] trial_in;
      logic        qbit_in;

      // shift in the next dividend bit and try to subtract the divisor
      assign trial_in = {crem_ff[k], cnq_ff[k][NW-1]};
      assign qbit_in  = trial_in >= {1'b0, cd_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (en) begin
            cv_ff[k+1] <= cv_ff[k];
         end
         if (en) begin
            cmode_ff[k+1] <= cmode_ff[k];
            clt_ff[k+1]   <= clt_ff[k];
            cgt_ff[k+1]   <= cgt_ff[k];
            ceq_ff[k+1]   <= ceq_ff[k];
            cres_ff[k+1]  <= cres_ff[k];
            csat_ff[k+1]  <= csat_ff[k];
            cdz_ff[k+1]   <= cdz_ff[k];
            cneg_ff[k+1]  <= cneg_ff[k];
            cd_ff[k+1]    <= cd_ff[k];
            crem_ff[k+1]  <= qbit_in ? 32'(trial_in - {1'b0, cd_ff[k]}) : trial_in[31:0];
            cnq_ff[k+1]   <= {cnq_ff[k][NW-2:0], qbit_in};
         end
      end
   end

   // ---------------- stage 5: quotient rounding
   logic               s5_v_ff;
   logic [3:0]         s5_mode_ff;
   logic               s5_lt_ff, s5_gt_ff, s5_eq_ff, s5_sat_ff, s5_dz_ff, s5_neg_ff;
   logic signed [31:0] s5_res_ff;
   logic [NW:0]        s5_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= cv_ff[NW];
      end
      if (en) begin
         s5_mode_ff <= cmode_ff[NW];
         s5_lt_ff   <= clt_ff[NW];
         s5_gt_ff   <= cgt_ff[NW];
         s5_eq_ff   <= ceq_ff[NW];
         s5_res_ff  <= cres_ff[NW];
         s5_sat_ff  <= csat_ff[NW];
         s5_dz_ff   <= cdz_ff[NW];
         s5_neg_ff  <= cneg_ff[NW];
         s5_q_ff    <= {1'b0, cnq_ff[NW]}
                       + (NW+1)'({crem_ff[NW], 1'b0} >= {1'b0, cd_ff[NW]});
      end
   end

   // ---------------- stage 6: quotient sign and clamp, output register
   rsp_type out_in;

   always_comb begin
      out_in.result         = s5_res_ff;
      out_in.saturated      = s5_sat_ff;
      out_in.divide_by_zero = s5_dz_ff;
      out_in.a_less         = s5_lt_ff;
      out_in.a_greater      = s5_gt_ff;
      out_in.a_equal        = s5_eq_ff;
      if (s5_mode_ff == MODE_DIV) begin
         priority if (s5_dz_ff) begin
            out_in.result    = '0;
            out_in.saturated = 1'b0;
         end else if (s5_neg_ff) begin
            if ((|s5_q_ff[NW:32]) || (s5_q_ff[31] && (|s5_q_ff[30:0]))) begin
               out_in.result    = MIN32;
               out_in.saturated = 1'b1;
            end else begin
               out_in.result    = 32'(-s5_q_ff[31:0]);
               out_in.saturated = 1'b0;
            end
         end else if (|s5_q_ff[NW:31]) begin
            out_in.result    = MAX32;
            out_in.saturated = 1'b1;
         end else begin
            out_in.result    = s5_q_ff[31:0];
            out_in.saturated = 1'b0;
         end
      end
   end

   rsp_type out_ff;
   logic    out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= s5_v_ff;
      end
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // exactly one ordering relation holds between the operands
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.a_less, rsp_data.a_greater, rsp_data.a_equal}))
      else $error("compare flags not one-hot");

   // divide by zero returns zero and never reports saturation
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result == '0 && !rsp_data.saturated)
      else $error("divide by zero result wrong");

   // a saturated result sits on one of the range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.result == MAX32 || rsp_data.result == MIN32)
      else $error("saturated result not at limit");
`endif

endmodule
